[hdl/sqr_pkg.sv]
// shared types, widths and constants for the sprite quad rotate to ndc block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sqr_pkg;

    localparam int FIELD_W     = 24;
    localparam int TURN_W      = 16;
    localparam int OUT_W       = 16;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int OFS_W       = 25;
    localparam int CS_W        = 33;
    localparam int Z_W         = 44;
    localparam int PROD_W      = 58;
    localparam int SUM_W       = 60;
    localparam int P_W         = 28;
    localparam int N_W         = 36;
    localparam int REM_W       = 37;
    localparam int QUO_W       = 15;
    localparam int DIV_W       = 14;
    localparam int CORNERS     = 4;
    localparam int LANES       = 8;
    localparam int MAX_STAGES  = 24;
    localparam int TRIG_STAGES_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd800;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd600;

    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
    // pi in q40, truncated
    localparam logic [41:0] PI_Q40 = 42'h3243F6A8885;
    localparam logic signed [CS_W-1:0] CORDIC_K = 33'sd652032874;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pivot_x;
        logic signed [FIELD_W-1:0] pivot_y;
        logic signed [FIELD_W-1:0] place_x;
        logic signed [FIELD_W-1:0] place_y;
        logic signed [FIELD_W-1:0] extent_x;
        logic signed [FIELD_W-1:0] extent_y;
        logic        [TURN_W-1:0]  turn;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] corner0_x;
        logic signed [OUT_W-1:0] corner0_y;
        logic signed [OUT_W-1:0] corner1_x;
        logic signed [OUT_W-1:0] corner1_y;
        logic signed [OUT_W-1:0] corner2_x;
        logic signed [OUT_W-1:0] corner2_y;
        logic signed [OUT_W-1:0] corner3_x;
        logic signed [OUT_W-1:0] corner3_y;
    } out_item_t;

    // corner offsets from the pivot and the screen position
    typedef struct packed {
        logic signed [OFS_W-1:0]   dxa;
        logic signed [OFS_W-1:0]   dxb;
        logic signed [OFS_W-1:0]   dya;
        logic signed [OFS_W-1:0]   dyb;
        logic signed [FIELD_W-1:0] place_x;
        logic signed [FIELD_W-1:0] place_y;
        logic        [1:0]         quad;
    } geom_t;

    typedef struct packed {
        logic signed [CS_W-1:0] x;
        logic signed [CS_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        geom_t                  geom;
    } cordic_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             sat;
    } div_lane_t;

    typedef div_lane_t [LANES-1:0] div_bus_t;

    // floor(2^e / d) by shift and subtract, e below 63
    function automatic longint pow2_div(input int e, input int d);
        longint q;
        longint rem;
        q   = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem << 1) | ((b == e) ? 64'sd1 : 64'sd0);
            q   = q << 1;
            if (rem >= longint'(d))
            begin
                rem = rem - longint'(d);
                q   = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in q40, pi/4 for i of zero, otherwise from the truncated alternating series in q60
    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        longint sum;
        longint term;
        int     k;
        sum = 0;
        if (i == 0)
        begin
            return Z_W'(((PI_Q61 >> 3) + (64'd1 << 19)) >> 20);
        end
        for (k = 0; k < 31; k++)
        begin
            if (i * (2 * k + 1) <= 60)
            begin
                term = pow2_div(60 - i * (2 * k + 1), 2 * k + 1);
                sum  = (k % 2 == 1) ? sum - term : sum + term;
            end
        end
        return Z_W'((sum + (64'sd1 <<< 19)) >>> 20);
    endfunction

endpackage

`default_nettype wire

[hdl/sprite_quad_rotate_to_ndc_unit.sv]
// top level: rotates the four sprite corners and maps them to normalized coordinates
// depends on sqr_pkg, sqr_cordic_cell and sqr_div_cell
`timescale 1ns / 1ps
`default_nettype none

// Takes one sprite per transfer and returns its four rotated corners in signed
// Q1.14 device coordinates, y flipped and saturated. A new sprite is taken every
// clock cycle while the output side keeps up. A sprite passes through one setup
// stage, one cell per rotation step in the sine/cosine chain, four stages for
// the quadrant fold, multiply, sum and numerator setup, fifteen division cells
// (one quotient bit each) and the output register. The whole chain stalls only
// while a result waits on out_ready. Window size writes must be made with no
// sprite in flight.

module sprite_quad_rotate_to_ndc_unit
    import sqr_pkg::*;
#(
    parameter int TRIG_STAGES = TRIG_STAGES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int NS = (TRIG_STAGES > MAX_STAGES) ? MAX_STAGES : TRIG_STAGES;

    logic en;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;
    logic [DIV_W-1:0] div_w;
    logic [DIV_W-1:0] div_h;

    // ---------------- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_WIDTH:  width_reg  <= cfg_data;
                REG_WINDOW_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a zero size acts as one
    assign w_eff = (width_reg == '0) ? CFG_W'(1) : width_reg;
    assign h_eff = (height_reg == '0) ? CFG_W'(1) : height_reg;
    assign div_w = {w_eff, 1'b0};
    assign div_h = {h_eff, 1'b0};

    // ---------------- setup stage
    logic    s0_valid_reg;
    cordic_t s0_reg;
    cordic_t s0_next;
    logic [55:0] angle_prod;

    always_comb
    begin
        angle_prod         = 56'(in_data.turn[13:0]) * 56'(PI_Q40);
        s0_next.x          = CORDIC_K;
        s0_next.y          = '0;
        s0_next.z          = $signed(Z_W'(angle_prod >> 15));
        s0_next.geom.dxa   = -OFS_W'(in_data.pivot_x);
        s0_next.geom.dxb   = OFS_W'(in_data.extent_x) - OFS_W'(in_data.pivot_x);
        s0_next.geom.dya   = -OFS_W'(in_data.pivot_y);
        s0_next.geom.dyb   = OFS_W'(in_data.extent_y) - OFS_W'(in_data.pivot_y);
        s0_next.geom.place_x = in_data.place_x;
        s0_next.geom.place_y = in_data.place_y;
        s0_next.geom.quad    = in_data.turn[15:14];
    end

    // ---------------- sine/cosine chain
    logic    cv [NS+1];
    cordic_t cd [NS+1];

    assign cv[0] = s0_valid_reg;
    assign cd[0] = s0_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        sqr_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (cv[i]),
            .data_in   (cd[i]),
            .valid_out (cv[i+1]),
            .data_out  (cd[i+1])
        );
    end

    // ---------------- quadrant fold
    logic q_valid_reg;
    logic signed [CS_W-1:0] c_reg, s_reg, c_next, s_next;
    geom_t q_geom_reg;

    always_comb
    begin
        case (cd[NS].geom.quad)
            2'd0:
            begin
                c_next = cd[NS].x;
                s_next = cd[NS].y;
            end
            2'd1:
            begin
                c_next = -cd[NS].y;
                s_next = cd[NS].x;
            end
            2'd2:
            begin
                c_next = -cd[NS].x;
                s_next = -cd[NS].y;
            end
            default:
            begin
                c_next = cd[NS].y;
                s_next = -cd[NS].x;
            end
        endcase
    end

    // ---------------- products
    logic m_valid_reg;
    logic signed [PROD_W-1:0] mxc_reg [2];
    logic signed [PROD_W-1:0] mxs_reg [2];
    logic signed [PROD_W-1:0] myc_reg [2];
    logic signed [PROD_W-1:0] mys_reg [2];
    logic signed [FIELD_W-1:0] m_px_reg, m_py_reg;

    // ---------------- rotated and translated corners
    logic p_valid_reg;
    logic signed [P_W-1:0] px_reg [CORNERS];
    logic signed [P_W-1:0] py_reg [CORNERS];
    logic signed [P_W-1:0] px_next [CORNERS];
    logic signed [P_W-1:0] py_next [CORNERS];
    logic signed [SUM_W-1:0] sx, sy;

    always_comb
    begin
        sx = '0;
        sy = '0;
        for (int k = 0; k < CORNERS; k++)
        begin
            sx = SUM_W'(mxc_reg[(k == 0 || k == 3) ? 0 : 1])
               - SUM_W'(mys_reg[(k < 2) ? 0 : 1]) + (SUM_W'(1) <<< 29);
            sy = SUM_W'(mxs_reg[(k == 0 || k == 3) ? 0 : 1])
               + SUM_W'(myc_reg[(k < 2) ? 0 : 1]) + (SUM_W'(1) <<< 29);
            px_next[k] = P_W'(m_px_reg) + P_W'(sx >>> 30);
            py_next[k] = P_W'(m_py_reg) + P_W'(sy >>> 30);
        end
    end

    // ---------------- numerators and division setup
    logic     n_valid_reg;
    div_bus_t n_reg;
    div_bus_t n_next;
    logic signed [N_W-1:0] num;
    logic [N_W-1:0] mag;
    logic [REM_W-1:0] dividend;
    logic [DIV_W-1:0] dsr;

    always_comb
    begin
        num      = '0;
        mag      = '0;
        dividend = '0;
        dsr      = '0;
        for (int j = 0; j < LANES; j++)
        begin
            if (j % 2 == 0)
            begin
                num = (N_W'(px_reg[j/2]) <<< 7) - (N_W'(w_eff) <<< 14);
                dsr = div_w;
            end
            else
            begin
                num = (N_W'(h_eff) <<< 14) - (N_W'(py_reg[j/2]) <<< 7);
                dsr = div_h;
            end
            mag      = num[N_W-1] ? -num : num;
            dividend = {mag, 1'b0} + REM_W'(dsr >> 1);
            n_next[j].rem = dividend;
            n_next[j].quo = '0;
            n_next[j].neg = num[N_W-1];
            n_next[j].sat = dividend >= (REM_W'(dsr) << QUO_W);
        end
    end

    // ---------------- division chain, one quotient bit per cell
    logic     dv [QUO_W+1];
    div_bus_t dd [QUO_W+1];

    assign dv[0] = n_valid_reg;
    assign dd[0] = n_reg;

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        sqr_div_cell #(
            .BIT (QUO_W - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .div_w     (div_w),
            .div_h     (div_h),
            .valid_in  (dv[j]),
            .data_in   (dd[j]),
            .valid_out (dv[j+1]),
            .data_out  (dd[j+1])
        );
    end

    // ---------------- sign, saturation and output register
    logic out_valid_reg;
    out_item_t out_reg;
    out_item_t out_next;
    logic [LANES-1:0][OUT_W-1:0] vals;

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            if (dd[QUO_W][j].sat)
            begin
                vals[j] = dd[QUO_W][j].neg ? 16'h8000 : 16'h7FFF;
            end
            else if (dd[QUO_W][j].neg)
            begin
                vals[j] = -{1'b0, dd[QUO_W][j].quo};
            end
            else
            begin
                vals[j] = {1'b0, dd[QUO_W][j].quo};
            end
        end
        out_next.corner0_x = vals[0];
        out_next.corner0_y = vals[1];
        out_next.corner1_x = vals[2];
        out_next.corner1_y = vals[3];
        out_next.corner2_x = vals[4];
        out_next.corner2_y = vals[5];
        out_next.corner3_x = vals[6];
        out_next.corner3_y = vals[7];
    end

    // whole chain advances unless a finished result is held
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            q_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            n_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg  <= in_valid;
            q_valid_reg   <= cv[NS];
            m_valid_reg   <= q_valid_reg;
            p_valid_reg   <= m_valid_reg;
            n_valid_reg   <= p_valid_reg;
            out_valid_reg <= dv[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg     <= s0_next;
            c_reg      <= c_next;
            s_reg      <= s_next;
            q_geom_reg <= cd[NS].geom;
            mxc_reg[0] <= PROD_W'(q_geom_reg.dxa) * PROD_W'(c_reg);
            mxc_reg[1] <= PROD_W'(q_geom_reg.dxb) * PROD_W'(c_reg);
            mxs_reg[0] <= PROD_W'(q_geom_reg.dxa) * PROD_W'(s_reg);
            mxs_reg[1] <= PROD_W'(q_geom_reg.dxb) * PROD_W'(s_reg);
            myc_reg[0] <= PROD_W'(q_geom_reg.dya) * PROD_W'(c_reg);
            myc_reg[1] <= PROD_W'(q_geom_reg.dyb) * PROD_W'(c_reg);
            mys_reg[0] <= PROD_W'(q_geom_reg.dya) * PROD_W'(s_reg);
            mys_reg[1] <= PROD_W'(q_geom_reg.dyb) * PROD_W'(s_reg);
            m_px_reg   <= q_geom_reg.place_x;
            m_py_reg   <= q_geom_reg.place_y;
            px_reg     <= px_next;
            py_reg     <= py_next;
            n_reg      <= n_next;
            out_reg    <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

[hdl/sqr_cordic_cell.sv]
// one rotation step of the sine/cosine chain, registered
// depends on sqr_pkg for the cordic_t bundle and the arctangent entries
`timescale 1ns / 1ps
`default_nettype none

module sqr_cordic_cell
    import sqr_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    valid_in,
    input  wire cordic_t data_in,
    output logic         valid_out,
    output cordic_t      data_out
);

    localparam logic signed [Z_W-1:0] ANGLE = atan_entry(STAGE);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;
    logic signed [CS_W-1:0] xs;
    logic signed [CS_W-1:0] ys;

    always_comb
    begin
        xs = data_in.x >>> STAGE;
        ys = data_in.y >>> STAGE;
        data_next = data_in;
        if (!data_in.z[Z_W-1])
        begin
            data_next.x = data_in.x - ys;
            data_next.y = data_in.y + xs;
            data_next.z = data_in.z - ANGLE;
        end
        else
        begin
            data_next.x = data_in.x + ys;
            data_next.y = data_in.y - xs;
            data_next.z = data_in.z + ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

[hdl/sqr_div_cell.sv]
// one quotient bit of the eight normalizing divisions, registered
// depends on sqr_pkg for the div_bus_t lanes
`timescale 1ns / 1ps
`default_nettype none

module sqr_div_cell
    import sqr_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [DIV_W-1:0] div_w,
    input  wire logic [DIV_W-1:0] div_h,
    input  wire logic             valid_in,
    input  wire div_bus_t         data_in,
    output logic                  valid_out,
    output div_bus_t              data_out
);

    logic     valid_reg;
    div_bus_t data_reg;
    div_bus_t data_next;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        data_next = data_in;
        trial     = '0;
        for (int k = 0; k < LANES; k++)
        begin
            // even lanes are x (width), odd lanes are y (height)
            trial = REM_W'((k % 2 == 0) ? div_w : div_h) << BIT;
            if (data_in[k].rem >= trial)
            begin
                data_next[k].rem      = data_in[k].rem - trial;
                data_next[k].quo[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

[test/sprite_quad_rotate_to_ndc_unit_test.sv]
// testbench for sprite_quad_rotate_to_ndc_unit: directed and random sprites checked
// against a behavioral predictor of the rotation and ndc mapping; depends on sqr_pkg
`timescale 1ns / 1ps

module sprite_quad_rotate_to_ndc_unit_test;
    import sqr_pkg::*;

    localparam int STAGES  = 16;
    localparam int LATENCY = STAGES + 21;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    sprite_quad_rotate_to_ndc_unit #(.TRIG_STAGES(STAGES)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    longint atan_rom [MAX_STAGES];
    longint win_w;
    longint win_h;
    out_item_t corners_expected [$];
    int  error_count;
    int  idle_cycles;
    bit  stall_mode;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_div(longint n, longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (mag * 2 + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic [OUT_W-1:0] clamp16(longint v);
        if (v > 32767)
        begin
            v = 32767;
        end
        if (v < -32768)
        begin
            v = -32768;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic void build_atan_rom();
        longint sum;
        longint term;
        logic [63:0] pi_q61;
        pi_q61 = 64'h6487ED5110B4611A;
        atan_rom[0] = longint'(((pi_q61 >> 3) + (64'd1 << 19)) >> 20);
        for (int i = 1; i < MAX_STAGES; i++)
        begin
            sum = 0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++)
            begin
                term = (64'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
                sum = (k % 2 == 1) ? sum - term : sum + term;
            end
            atan_rom[i] = (sum + (64'sd1 <<< 19)) >>> 20;
        end
    endfunction

    function automatic out_item_t project_quad(in_item_t s);
        logic [63:0] pi_q61;
        longint r, z, x, y, xs, ys, c, sn, w, h;
        longint dx [4];
        longint dy [4];
        longint px, py, qx, qy, ex, ey, rx, ry, nx, ny;
        logic [OUT_W-1:0] lane [8];
        pi_q61 = 64'h6487ED5110B4611A;
        r = longint'(s.turn[13:0]);
        z = (r * longint'(pi_q61 >> 21)) >>> 15;
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - atan_rom[i];
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + atan_rom[i];
            end
        end
        case (s.turn[15:14])
            2'd0: begin c = x;  sn = y;  end
            2'd1: begin c = -y; sn = x;  end
            2'd2: begin c = -x; sn = -y; end
            default: begin c = y; sn = -x; end
        endcase
        px = s.pivot_x; py = s.pivot_y; qx = s.place_x; qy = s.place_y;
        ex = s.extent_x; ey = s.extent_y;
        w = (win_w == 0) ? 1 : win_w;
        h = (win_h == 0) ? 1 : win_h;
        dx[0] = -px;     dy[0] = -py;
        dx[1] = ex - px; dy[1] = -py;
        dx[2] = ex - px; dy[2] = ey - py;
        dx[3] = -px;     dy[3] = ey - py;
        for (int k = 0; k < CORNERS; k++)
        begin
            rx = (dx[k] * c - dy[k] * sn + (64'sd1 <<< 29)) >>> 30;
            ry = (dx[k] * sn + dy[k] * c + (64'sd1 <<< 29)) >>> 30;
            nx = (2 * (qx + rx) - 256 * w) * 64;
            ny = (256 * h - 2 * (qy + ry)) * 64;
            lane[2 * k] = clamp16(round_div(nx, w));
            lane[2 * k + 1] = clamp16(round_div(ny, h));
        end
        return {lane[0], lane[1], lane[2], lane[3], lane[4], lane[5], lane[6], lane[7]};
    endfunction

    task automatic compare_lane(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d got %0d", name, $signed(want), $signed(got));
            error_count++;
        end
    endtask

    // result checker and receiver stall pattern
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (corners_expected.size() == 0)
                begin
                    $error("unexpected result transfer");
                    error_count++;
                end
                else
                begin
                    want = corners_expected.pop_front();
                    compare_lane("corner0_x", want.corner0_x, out_data.corner0_x);
                    compare_lane("corner0_y", want.corner0_y, out_data.corner0_y);
                    compare_lane("corner1_x", want.corner1_x, out_data.corner1_x);
                    compare_lane("corner1_y", want.corner1_y, out_data.corner1_y);
                    compare_lane("corner2_x", want.corner2_x, out_data.corner2_x);
                    compare_lane("corner2_y", want.corner2_y, out_data.corner2_y);
                    compare_lane("corner3_x", want.corner3_x, out_data.corner3_x);
                    compare_lane("corner3_y", want.corner3_y, out_data.corner3_y);
                end
            end
            if ($urandom_range(0, 63) == 0)
            begin
                stall_mode <= ~stall_mode;
            end
            out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sprite_quad_rotate_to_ndc_unit_test failed");
            $finish;
        end
    end

    int burst_left;

    // valid stays high across a burst and drops only for a gap
    task automatic send_sprite(in_item_t s);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= s;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        corners_expected.push_back(project_quad(s));
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (corners_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_window(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        cfg_we <= 1'b1;
        cfg_index <= REG_WINDOW_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_WINDOW_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        win_w = w;
        win_h = h;
    endtask

    function automatic logic [FIELD_W-1:0] pick_field();
        case ($urandom_range(0, 5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return FIELD_W'($urandom_range(0, 1 << 20)) - 24'd524288;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_sprite(bit screen_sized);
        in_item_t s;
        if (screen_sized)
        begin
            s.pivot_x  = FIELD_W'($urandom_range(0, 64 * 256));
            s.pivot_y  = FIELD_W'($urandom_range(0, 64 * 256));
            s.place_x  = FIELD_W'($urandom_range(0, 4096 * 256));
            s.place_y  = FIELD_W'($urandom_range(0, 4096 * 256));
            s.extent_x = FIELD_W'($urandom_range(0, 128 * 256));
            s.extent_y = FIELD_W'($urandom_range(0, 128 * 256));
        end
        else
        begin
            s.pivot_x = pick_field(); s.pivot_y = pick_field();
            s.place_x = pick_field(); s.place_y = pick_field();
            s.extent_x = pick_field(); s.extent_y = pick_field();
        end
        s.turn = TURN_W'($urandom);
        return s;
    endfunction

    task automatic test_directed();
        in_item_t s;
        logic [TURN_W-1:0] turns [8];
        turns = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h3FFF, 16'hFFFF,
                  16'h2000, 16'h0001};
        foreach (turns[i])
        begin
            s = '{pivot_x: 24'sd2560, pivot_y: 24'sd1280, place_x: 24'sd102400,
                  place_y: 24'sd76800, extent_x: 24'sd5120, extent_y: 24'sd2560,
                  turn: turns[i]};
            send_sprite(s);
        end
        // negative extents fold the quad over the pivot
        s = '{pivot_x: 24'sd0, pivot_y: 24'sd0, place_x: 24'sd1000, place_y: 24'sd1000,
              extent_x: -24'sd8000, extent_y: -24'sd4000, turn: 16'h1234};
        send_sprite(s);
        // field extremes drive saturation both ways
        s = '{pivot_x: 24'h800000, pivot_y: 24'h800000, place_x: 24'h7FFFFF,
              place_y: 24'h7FFFFF, extent_x: 24'h7FFFFF, extent_y: 24'h7FFFFF,
              turn: 16'h0000};
        send_sprite(s);
        s = '{pivot_x: 24'h7FFFFF, pivot_y: 24'h7FFFFF, place_x: 24'h800000,
              place_y: 24'h800000, extent_x: 24'h800000, extent_y: 24'h800000,
              turn: 16'hFFFF};
        send_sprite(s);
        s = '{default: '1};
        send_sprite(s);
        s = '{default: '0};
        send_sprite(s);
        drain_pipeline();
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
        begin
            send_sprite(random_sprite($urandom_range(0, 3) != 0));
        end
        drain_pipeline();
    endtask

    task automatic test_window_sizes();
        // zero acts as one, sizes above the nominal range are used as written
        write_window(13'd0, 13'd0);
        test_random(60);
        write_window(13'd1, 13'd1);
        test_random(60);
        write_window(13'h1FFF, 13'h1FFF);
        test_random(60);
        write_window(13'd4096, 13'd1);
        test_random(60);
        write_window(13'h1555, 13'h0AAA);
        test_random(60);
        write_window(13'd640, 13'd480);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WINDOW_WIDTH;
        cfg_data = '0;
        error_count = 0;
        idle_cycles = 0;
        stall_mode = 1'b0;
        burst_left = 0;
        win_w = WIDTH_RESET;
        win_h = HEIGHT_RESET;
        build_atan_rom();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600);
        test_window_sizes();
        test_random(400);
        if (error_count == 0)
        begin
            $display("sprite_quad_rotate_to_ndc_unit_test passed");
        end
        else
        begin
            $display("sprite_quad_rotate_to_ndc_unit_test failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/sqr_pkg.sv
hdl/sqr_cordic_cell.sv
hdl/sqr_div_cell.sv
hdl/sprite_quad_rotate_to_ndc_unit.sv
test/sprite_quad_rotate_to_ndc_unit_test.sv
